### rtl/core/ookpwt_pkg.sv
package ookpwt_pkg;

    typedef struct packed {
        logic       start_req;
        logic [3:0] command;
    } t_in;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic rejected;
        logic frame_done;
    } t_out;

    localparam int UNIT_TICKS_W   = 24;
    localparam int REPEAT_COUNT_W = 4;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 1;
    localparam int COMMAND_W      = 4;
    localparam int ROM_BITS       = 64;
    localparam int ROM_ROWS       = 16;
    localparam int ROM_POS_W      = 6;
    localparam int UNITS_W        = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT = 1'd1;

    localparam logic [UNIT_TICKS_W-1:0]   UNIT_TICKS_RESET   = 24'd235000;
    localparam logic [REPEAT_COUNT_W-1:0] REPEAT_COUNT_RESET = 4'd8;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_BIT_HIGH  = 3'd1;
    localparam logic [2:0] PH_BIT_LOW   = 3'd2;
    localparam logic [2:0] PH_SYNC_HIGH = 3'd3;
    localparam logic [2:0] PH_SYNC_LOW  = 3'd4;

    localparam logic [UNITS_W-1:0] UNITS_SHORT    = 5'd1;
    localparam logic [UNITS_W-1:0] UNITS_LONG     = 5'd3;
    localparam logic [UNITS_W-1:0] SYNC_LOW_UNITS = 5'd29;

    localparam logic [19:0] PACKET_PREFIX = 20'b01110010011111100000;

    typedef logic [0:ROM_BITS-1] t_packet;

    // Bit 0 of each packet is its leftmost literal bit.
    localparam t_packet PACKET_ROM [ROM_ROWS] = '{
        {PACKET_PREFIX, 14'b11110011110100, 30'd0},
        {PACKET_PREFIX, 14'b11100011110000, 30'd0},
        {PACKET_PREFIX, 14'b11010011111000, 30'd0},
        {PACKET_PREFIX, 14'b11000011111100, 30'd0},
        {PACKET_PREFIX, 14'b10110011100100, 30'd0},
        {PACKET_PREFIX, 14'b10100011100000, 30'd0},
        {PACKET_PREFIX, 14'b01110011010100, 30'd0},
        {PACKET_PREFIX, 14'b01100011010000, 30'd0},
        {PACKET_PREFIX, 14'b01000011011100, 30'd0},
        {PACKET_PREFIX, 14'b10000011101100, 30'd0},
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
    };

    function automatic logic packet_bit(input logic [COMMAND_W-1:0] cmd,
                                        input logic [ROM_POS_W-1:0] pos);
        t_packet row;
        row = PACKET_ROM[cmd];
        return row[pos];
    endfunction

endpackage

### rtl/core/ook_pulse_width_transmitter.sv
// On-off-keyed pulse-width transmitter. Every accepted input transaction is one
// tick of the pulse timer and produces exactly one output transaction through a
// register, so the block sustains one transaction per clock; it stalls its input
// only while a finished result is held by a stalled output. A start request
// with a command below COMMAND_COUNT sends that command's PACKET_BITS-bit
// packet repeat_count times, each frame followed by a one-tick sync pulse and
// 29 low units. A 0 bit is 1 unit high and 3 low, a 1 bit is 3 high and 1 low,
// and a unit lasts unit_ticks accepted ticks. Starts while busy or with an
// unknown command are ignored and flagged in rejected. Registers should be
// written while the transmitter is idle.
module ook_pulse_width_transmitter #(
    parameter int PACKET_BITS   = 34,
    parameter int COMMAND_COUNT = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ookpwt_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ookpwt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  ookpwt_pkg::t_in                        i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output ookpwt_pkg::t_out                       o_out_data
);

    localparam int BPW = (PACKET_BITS > 1) ? $clog2(PACKET_BITS) : 1;
    localparam logic [BPW:0] BIT_COUNT = (BPW+1)'(PACKET_BITS);
    localparam logic [ookpwt_pkg::COMMAND_W:0] CMD_LIMIT =
        (ookpwt_pkg::COMMAND_W+1)'(COMMAND_COUNT);

    logic [ookpwt_pkg::UNIT_TICKS_W-1:0]   r_unit_ticks;
    logic [ookpwt_pkg::REPEAT_COUNT_W-1:0] r_repeat_count;

    logic [2:0]                             r_phase, n_phase;
    logic [ookpwt_pkg::UNIT_TICKS_W-1:0]   r_unit_counter, n_unit_counter;
    logic [ookpwt_pkg::UNITS_W-1:0]        r_units_left, n_units_left;
    logic [BPW-1:0]                         r_bit_position, n_bit_position;
    logic [ookpwt_pkg::REPEAT_COUNT_W-1:0] r_repeats_done, n_repeats_done;
    logic [ookpwt_pkg::COMMAND_W-1:0]      r_active_command, n_active_command;

    logic                                   r_out_valid, n_out_valid;
    ookpwt_pkg::t_out                       r_out, n_out;

    logic                                   in_accept;
    logic                                   cmd_ok;
    logic [ookpwt_pkg::UNIT_TICKS_W-1:0]   ticks;
    logic [ookpwt_pkg::REPEAT_COUNT_W-1:0] reps;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign cmd_ok = {1'b0, i_in_data.command} < CMD_LIMIT;
    assign ticks  = (r_unit_ticks == '0) ? ookpwt_pkg::UNIT_TICKS_W'(1) : r_unit_ticks;
    assign reps   = (r_repeat_count == '0) ? ookpwt_pkg::REPEAT_COUNT_W'(1) : r_repeat_count;

    always_comb begin : step
        logic [2:0]                             ph;
        logic [ookpwt_pkg::UNIT_TICKS_W-1:0]   uc;
        logic [ookpwt_pkg::UNITS_W-1:0]        ul;
        logic [BPW-1:0]                         bp;
        logic [ookpwt_pkg::REPEAT_COUNT_W-1:0] rd;
        logic [ookpwt_pkg::COMMAND_W-1:0]      ac;
        ookpwt_pkg::t_out                       res;

        ph  = r_phase;
        uc  = r_unit_counter;
        ul  = r_units_left;
        bp  = r_bit_position;
        rd  = r_repeats_done;
        ac  = r_active_command;
        res = '0;

        res.rejected = i_in_data.start_req && !(r_phase == ookpwt_pkg::PH_IDLE && cmd_ok);

        if (r_phase == ookpwt_pkg::PH_IDLE && i_in_data.start_req && cmd_ok) begin
            ph = ookpwt_pkg::PH_BIT_HIGH;
            uc = '0;
            bp = '0;
            rd = '0;
            ac = i_in_data.command;
            ul = ookpwt_pkg::packet_bit(ac, '0) ? ookpwt_pkg::UNITS_LONG
                                                 : ookpwt_pkg::UNITS_SHORT;
        end

        if (ph != ookpwt_pkg::PH_IDLE) begin
            res.busy_res  = 1'b1;
            res.pin_level = (ph == ookpwt_pkg::PH_BIT_HIGH) || (ph == ookpwt_pkg::PH_SYNC_HIGH);
            if (ph == ookpwt_pkg::PH_SYNC_HIGH) begin
                ph = ookpwt_pkg::PH_SYNC_LOW;
                uc = '0;
                ul = ookpwt_pkg::SYNC_LOW_UNITS;
            end else if (({1'b0, uc} + 25'd1) < {1'b0, ticks}) begin
                uc = uc + 24'd1;
            end else begin
                uc = '0;
                if (ul > ookpwt_pkg::UNITS_SHORT) begin
                    ul = ul - ookpwt_pkg::UNITS_SHORT;
                end else begin
                    ul = '0;
                    case (ph)
                        ookpwt_pkg::PH_BIT_HIGH: begin
                            ph = ookpwt_pkg::PH_BIT_LOW;
                            ul = ookpwt_pkg::packet_bit(ac, ookpwt_pkg::ROM_POS_W'(bp))
                                 ? ookpwt_pkg::UNITS_SHORT : ookpwt_pkg::UNITS_LONG;
                        end
                        ookpwt_pkg::PH_BIT_LOW: begin
                            if (({1'b0, bp} + (BPW+1)'(1)) >= BIT_COUNT) begin
                                bp = '0;
                                ph = ookpwt_pkg::PH_SYNC_HIGH;
                            end else begin
                                bp = bp + BPW'(1);
                                ph = ookpwt_pkg::PH_BIT_HIGH;
                                ul = ookpwt_pkg::packet_bit(ac, ookpwt_pkg::ROM_POS_W'(bp))
                                     ? ookpwt_pkg::UNITS_LONG : ookpwt_pkg::UNITS_SHORT;
                            end
                        end
                        ookpwt_pkg::PH_SYNC_LOW: begin
                            rd = rd + ookpwt_pkg::REPEAT_COUNT_W'(1);
                            bp = '0;
                            if (rd == '0 || rd >= reps) begin
                                ph = ookpwt_pkg::PH_IDLE;
                                rd = '0;
                                res.frame_done = 1'b1;
                            end else begin
                                ph = ookpwt_pkg::PH_BIT_HIGH;
                                ul = ookpwt_pkg::packet_bit(ac, '0)
                                     ? ookpwt_pkg::UNITS_LONG : ookpwt_pkg::UNITS_SHORT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        n_phase          = r_phase;
        n_unit_counter   = r_unit_counter;
        n_units_left     = r_units_left;
        n_bit_position   = r_bit_position;
        n_repeats_done   = r_repeats_done;
        n_active_command = r_active_command;
        n_out            = r_out;
        n_out_valid      = r_out_valid && i_out_stall;
        if (in_accept) begin
            n_phase          = ph;
            n_unit_counter   = uc;
            n_units_left     = ul;
            n_bit_position   = bp;
            n_repeats_done   = rd;
            n_active_command = ac;
            n_out            = res;
            n_out_valid      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks     <= ookpwt_pkg::UNIT_TICKS_RESET;
            r_repeat_count   <= ookpwt_pkg::REPEAT_COUNT_RESET;
            r_phase          <= ookpwt_pkg::PH_IDLE;
            r_unit_counter   <= '0;
            r_units_left     <= '0;
            r_bit_position   <= '0;
            r_repeats_done   <= '0;
            r_active_command <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == ookpwt_pkg::CFG_UNIT_TICKS) begin
                r_unit_ticks <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == ookpwt_pkg::CFG_REPEAT_COUNT) begin
                r_repeat_count <= i_cfg_data[ookpwt_pkg::REPEAT_COUNT_W-1:0];
            end
            r_phase          <= n_phase;
            r_unit_counter   <= n_unit_counter;
            r_units_left     <= n_units_left;
            r_bit_position   <= n_bit_position;
            r_repeats_done   <= n_repeats_done;
            r_active_command <= n_active_command;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |-> r_out.busy_res)
        else $error("frame_done reported outside a transmission");

    a_idle_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ookpwt_pkg::PH_IDLE |->
            r_unit_counter == '0 && r_units_left == '0 && r_bit_position == '0 &&
            r_repeats_done == '0)
        else $error("timing counters not cleared while idle");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase == ookpwt_pkg::PH_IDLE && i_in_data.start_req && cmd_ok
            |=> r_phase != ookpwt_pkg::PH_IDLE && r_out.busy_res && r_out.pin_level)
        else $error("accepted start did not begin a transmission");

endmodule
